>>> hw/rtl/lwr_pkg.sv
// shared constants and types for the longest window within range limit block
`timescale 1ns / 1ps
`default_nettype none
package lwr_pkg;

    localparam int MAX_WINDOW = 4096;
    localparam int SAMPLE_W   = 32;
    localparam int LIMIT_W    = 32;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int IN_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * LEN_W + 7) / 8) * 8;

    // suffix max and min held by one cell, over its sample up to the newest
    typedef struct packed {
        logic [SAMPLE_W-1:0] smax;
        logic [SAMPLE_W-1:0] smin;
    } t_agg;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                load;
        logic                shift;
        logic [IDX_W-1:0]    widx;
        logic [SAMPLE_W-1:0] key;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> hw/rtl/lwr_cell.sv
// one window cell: suffix max and min of the samples from its slot to the newest
`timescale 1ns / 1ps
`default_nettype none
module lwr_cell (
    input  wire logic                    i_clk,
    input  wire lwr_pkg::t_cell_ctl      i_ctl,
    input  wire logic [lwr_pkg::IDX_W-1:0] i_idx,
    input  wire lwr_pkg::t_agg           i_next,
    output lwr_pkg::t_agg                o_agg
);

    lwr_pkg::t_agg r_agg;
    lwr_pkg::t_agg n_agg;
    lwr_pkg::t_agg w_base;

    always_comb begin
        // a front drop moves every cell one slot toward the front
        w_base = i_ctl.shift ? i_next : r_agg;
        n_agg  = w_base;
        if (i_ctl.load) begin
            if (i_ctl.widx == i_idx) begin
                n_agg.smax = i_ctl.key;
                n_agg.smin = i_ctl.key;
            end else begin
                if ($signed(i_ctl.key) > $signed(w_base.smax)) begin
                    n_agg.smax = i_ctl.key;
                end
                if ($signed(i_ctl.key) < $signed(w_base.smin)) begin
                    n_agg.smin = i_ctl.key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_agg <= n_agg;
    end

    assign o_agg = r_agg;

endmodule
`default_nettype wire

>>> hw/rtl/lwr_ctrl.sv
// controller: window length, front drops, best length, config and output register
`timescale 1ns / 1ps
`default_nettype none
module lwr_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lwr_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_s_tvalid,
    input  wire logic [lwr_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                          i_last,
    output logic                               o_s_tready,
    input  wire logic                          i_m_tready,
    input  wire lwr_pkg::t_agg                 i_front,
    output lwr_pkg::t_cell_ctl                 o_ctl,
    output logic                               o_m_tvalid,
    output logic [lwr_pkg::LEN_W-1:0]          o_window_len,
    output logic [lwr_pkg::LEN_W-1:0]          o_best_len,
    output logic                               o_overflow,
    output logic                               o_done_res
);

    typedef enum logic {
        S_IDLE,
        S_SHRINK
    } t_state;

    t_state                        r_state;
    logic [lwr_pkg::LEN_W-1:0]     r_len;
    logic [lwr_pkg::LEN_W-1:0]     r_best;
    logic [lwr_pkg::LIMIT_W-1:0]   r_limit;
    logic                          r_last;
    logic                          r_ovf;
    logic                          r_out_valid;
    logic [lwr_pkg::LEN_W-1:0]     r_out_wlen;
    logic [lwr_pkg::LEN_W-1:0]     r_out_best;
    logic                          r_out_ovf;
    logic                          r_out_last;

    logic                          w_accept;
    logic                          w_full;
    logic [lwr_pkg::LEN_W-1:0]     w_len_m1;
    logic [lwr_pkg::SAMPLE_W:0]    w_diff;
    logic                          w_over;
    logic                          w_out_free;
    logic                          w_out_load;
    logic [lwr_pkg::LEN_W-1:0]     w_best_n;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && (r_state == S_IDLE);
    assign w_full     = (r_len == lwr_pkg::LEN_W'(lwr_pkg::MAX_WINDOW));
    assign w_len_m1   = r_len - lwr_pkg::LEN_W'(1);

    // front cell holds max and min of the whole window; difference is exact
    assign w_diff = $signed({i_front.smax[lwr_pkg::SAMPLE_W-1], i_front.smax})
                  - $signed({i_front.smin[lwr_pkg::SAMPLE_W-1], i_front.smin});
    assign w_over = (w_diff > {1'b0, r_limit});

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_out_load = (r_state == S_SHRINK) && !w_over && w_out_free;
    assign w_best_n   = (r_len > r_best) ? r_len : r_best;

    always_comb begin
        o_ctl.load  = w_accept;
        o_ctl.shift = (w_accept && w_full) || ((r_state == S_SHRINK) && w_over);
        o_ctl.key   = i_sample;
        // a full window drops its oldest item, so the new one lands in the top slot
        o_ctl.widx  = w_full ? w_len_m1[lwr_pkg::IDX_W-1:0] : r_len[lwr_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_best      <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!w_full) begin
                            r_len <= r_len + lwr_pkg::LEN_W'(1);
                        end
                        r_ovf   <= w_full;
                        r_last  <= i_last;
                        r_state <= S_SHRINK;
                    end
                end
                S_SHRINK: begin
                    if (w_over) begin
                        r_len <= w_len_m1;
                    end else if (w_out_free) begin
                        r_out_wlen  <= r_len;
                        r_out_best  <= w_best_n;
                        r_out_ovf   <= r_ovf;
                        r_out_last  <= r_last;
                        if (r_last) begin
                            r_len  <= '0;
                            r_best <= '0;
                        end else begin
                            r_best <= w_best_n;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_window_len = r_out_wlen;
    assign o_best_len   = r_out_best;
    assign o_overflow   = r_out_ovf;
    assign o_done_res   = r_out_last;

endmodule
`default_nettype wire

>>> hw/rtl/longest_window_within_range_limit_top.sv
// top level: longest window whose max minus min stays within a limit
//
// usage
//   slave stream carries one signed sample per item, tlast closes an array
//   master stream carries one result per item: current window length and
//   best length so far in tdata, overflow in tuser, tlast echoes the input
//   i_cfg_we/i_cfg_wdata write the range limit; write only while idle
// timing
//   the window lives in a row of MAX_WINDOW cells, front at cell 0; each
//   cell keeps max and min from its sample to the newest one
//   an item is taken in the idle state, then the shrink state drops samples
//   from the window front while max minus min exceeds the limit, and then
//   forms the result; each sample is dropped at most once
//   the single front compare of cell 0 sets the pace of the drop loop
// reset and stalls
//   reset empties the window, clears best length and the limit, no cells are
//   cleared; a stalled receiver holds the result register, one more item is
//   taken and held in the cells until the result register frees up
`timescale 1ns / 1ps
`default_nettype none
module longest_window_within_range_limit_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [lwr_pkg::LIMIT_W-1:0]          i_cfg_wdata,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [lwr_pkg::IN_TDATA_W-1:0]       i_s_tdata,  // sample
    input  wire logic                                 i_s_tlast,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [lwr_pkg::OUT_TDATA_W-1:0]           o_m_tdata,  // window_len, best_len
    output logic                                      o_m_tuser,  // overflow
    output logic                                      o_m_tlast
);

    localparam int PAD_W = lwr_pkg::OUT_TDATA_W - 2 * lwr_pkg::LEN_W;

    lwr_pkg::t_cell_ctl            w_ctl;
    lwr_pkg::t_agg                 w_agg  [lwr_pkg::MAX_WINDOW];
    lwr_pkg::t_agg                 w_next [lwr_pkg::MAX_WINDOW];
    logic [lwr_pkg::LEN_W-1:0]     w_wlen;
    logic [lwr_pkg::LEN_W-1:0]     w_best;

    lwr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_sample     (i_s_tdata[lwr_pkg::SAMPLE_W-1:0]),
        .i_last       (i_s_tlast),
        .o_s_tready   (o_s_tready),
        .i_m_tready   (i_m_tready),
        .i_front      (w_agg[0]),
        .o_ctl        (w_ctl),
        .o_m_tvalid   (o_m_tvalid),
        .o_window_len (w_wlen),
        .o_best_len   (w_best),
        .o_overflow   (o_m_tuser),
        .o_done_res   (o_m_tlast)
    );

    for (genvar g = 0; g < lwr_pkg::MAX_WINDOW; g++) begin : g_cell
        if (g == lwr_pkg::MAX_WINDOW - 1) begin : g_end
            // the top cell has no neighbor; its contents are stale after a drop
            assign w_next[g] = w_agg[g];
        end else begin : g_mid
            assign w_next[g] = w_agg[g+1];
        end

        lwr_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_idx  (lwr_pkg::IDX_W'(g)),
            .i_next (w_next[g]),
            .o_agg  (w_agg[g])
        );
    end

    assign o_m_tdata = {{PAD_W{1'b0}}, w_best, w_wlen};

endmodule
`default_nettype wire

>>> hw/rtl/lwr_checker.sv
// port-level checks for the longest window block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module lwr_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_ready,
    input  wire logic [lwr_pkg::OUT_TDATA_W-1:0]      i_out_data,
    input  wire logic                                 i_out_user
);

    logic [lwr_pkg::LEN_W-1:0] w_wlen;
    logic [lwr_pkg::LEN_W-1:0] w_best;

    assign w_wlen = i_out_data[lwr_pkg::LEN_W-1:0];
    assign w_best = i_out_data[2*lwr_pkg::LEN_W-1:lwr_pkg::LEN_W];

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (w_wlen != '0) &&
                        (w_wlen <= lwr_pkg::LEN_W'(lwr_pkg::MAX_WINDOW)) &&
                        (w_best >= w_wlen))
        else $error("window length out of range or above best length");

    // a full window was seen in this array, so best must be at the cap
    a_ovf_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_user |-> (w_best == lwr_pkg::LEN_W'(lwr_pkg::MAX_WINDOW)))
        else $error("overflow without a full best length");

endmodule

bind longest_window_within_range_limit_top lwr_checker u_lwr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_tvalid),
    .i_out_ready (i_m_tready),
    .i_out_data  (o_m_tdata),
    .i_out_user  (o_m_tuser)
);
`default_nettype wire
